/* sv/pbm_pkg.sv */
// shared types and codes of the two-level priority bitmap unit
package pbm_pkg;

    // operation codes carried in the cmd field
    localparam logic CMD_SET = 1'b0;
    localparam logic CMD_CLR = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] priority_req;
    } req_word_t;

    typedef struct packed {
        logic [8:0] highest_plus_one;
        logic       none_ready;
    } rsp_word_t;

endpackage

/* sv/two_level_priority_bitmap_unit.sv */
// top level of the two-level priority bitmap unit
//
//  channel | signals                        | word
//  --------+--------------------------------+-----------------------------------
//  req     | req_valid, req_ready, req_data | cmd, priority_req
//  rsp     | rsp_valid, rsp_ready, rsp_data | highest_plus_one, none_ready
//
// each word is handled in order: accept and read the addressed bitmap word, modify and
// write it back while reading the word picked by the new summary, then search that word
// in one pass and load the result; the single read port of the word memory sets the pace
// reset clears the summary register and the per-entry valid bits, so no clearing pass
// a finished result waits in the rsp register; the next word is taken meanwhile and
// holds in the search step only if the previous result is still not taken
module two_level_priority_bitmap_unit #(
    parameter int WORD_BITS = 16,
    parameter int NUM_WORDS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  pbm_pkg::req_word_t req_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output pbm_pkg::rsp_word_t rsp_data
);

    // widths derived from the map geometry
    localparam int AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BW    = $clog2(WORD_BITS);
    localparam int MAX_K = 255 / WORD_BITS;
    localparam int KW    = $clog2(MAX_K + 1);
    localparam int TPW   = $clog2(NUM_WORDS + 1);
    localparam int LPW   = $clog2(WORD_BITS + 1);

    // sequencer codes
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MODIFY = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;

    logic [1:0]           state_reg, state_next;

    // item held through the modify step
    logic                 cmd_reg;
    logic [AW-1:0]        widx_reg;
    logic [BW-1:0]        bit_reg;
    logic                 in_range_reg;

    logic [NUM_WORDS-1:0] summary_reg, summary_next;
    logic [TPW-1:0]       top_reg;
    logic [AW-1:0]        top_m1_reg;
    logic                 fwd_reg;
    logic [WORD_BITS-1:0] fwd_word_reg;

    logic                 rsp_valid_reg;
    pbm_pkg::rsp_word_t   rsp_data_reg;

    // decode of the incoming priority into word index and bit
    logic [KW-1:0]        dec_widx;
    logic [BW-1:0]        dec_bit;
    logic                 dec_in_range;

    // memory ports
    logic                 ram_wr_en;
    logic                 ram_rd_en;
    logic [AW-1:0]        ram_rd_addr;
    logic [WORD_BITS-1:0] ram_rd_data;

    // modify step
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] word_new;
    logic [TPW-1:0]       top_next;
    logic [AW-1:0]        top_m1_next;

    // search step
    logic [WORD_BITS-1:0] search_word;
    logic [LPW-1:0]       lead_pos;
    logic [15:0]          result_sum;
    logic                 req_fire;
    logic                 rsp_load;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_load  = (state_reg == ST_SEARCH) && (!rsp_valid_reg || rsp_ready);

    // word index is the largest k with k * WORD_BITS not above the priority
    always_comb
    begin
        dec_widx = '0;
        dec_bit  = BW'(req_data.priority_req);
        for (int k = 1; k <= MAX_K; k++)
        begin
            if (req_data.priority_req >= 8'(k * WORD_BITS))
            begin
                dec_widx = KW'(k);
                dec_bit  = BW'(req_data.priority_req - 8'(k * WORD_BITS));
            end
        end
        dec_in_range = (32'(dec_widx) < 32'(NUM_WORDS));
    end

    // read-modify-write of the addressed word
    assign bit_mask = WORD_BITS'(1) << bit_reg;
    assign word_new = (cmd_reg == pbm_pkg::CMD_SET) ? (ram_rd_data | bit_mask)
                                                    : (ram_rd_data & ~bit_mask);
    assign ram_wr_en = (state_reg == ST_MODIFY) && in_range_reg;

    always_comb
    begin
        summary_next = summary_reg;
        if (in_range_reg)
        begin
            if (cmd_reg == pbm_pkg::CMD_SET)
            begin
                summary_next[widx_reg] = 1'b1;
            end
            else if (word_new == '0)
            begin
                summary_next[widx_reg] = 1'b0;
            end
        end
    end

    // first level search on the updated summary
    pbm_lead_one #(
        .WIDTH(NUM_WORDS)
    ) u_top_search (
        .vec          (summary_next),
        .pos_plus_one (top_next)
    );

    assign top_m1_next = AW'(top_next - TPW'(1));

    // one read port: item word at accept, top word during modify
    always_comb
    begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = AW'(dec_widx);
        if (req_fire)
        begin
            ram_rd_en = 1'b1;
        end
        else if (state_reg == ST_MODIFY)
        begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = top_m1_next;
        end
    end

    pbm_word_ram #(
        .WORD_BITS (WORD_BITS),
        .NUM_WORDS (NUM_WORDS),
        .AW        (AW)
    ) u_word_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ram_wr_en),
        .wr_addr (widx_reg),
        .wr_data (word_new),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // the write and the top read can hit the same entry; take the fresh word then
    assign search_word = fwd_reg ? fwd_word_reg : ram_rd_data;

    pbm_lead_one #(
        .WIDTH(WORD_BITS)
    ) u_word_search (
        .vec          (search_word),
        .pos_plus_one (lead_pos)
    );

    assign result_sum = 16'(top_m1_reg) * 16'(WORD_BITS) + 16'(lead_pos);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_MODIFY;
                end
            end
            ST_MODIFY:
            begin
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            summary_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_MODIFY)
            begin
                summary_reg <= summary_next;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg      <= req_data.cmd;
            widx_reg     <= AW'(dec_widx);
            bit_reg      <= dec_bit;
            in_range_reg <= dec_in_range;
        end
        if (state_reg == ST_MODIFY)
        begin
            top_reg      <= top_next;
            top_m1_reg   <= top_m1_next;
            fwd_reg      <= in_range_reg && (top_m1_next == widx_reg);
            fwd_word_reg <= word_new;
        end
        if (rsp_load)
        begin
            rsp_data_reg.highest_plus_one <= (top_reg == '0) ? 9'd0 : result_sum[8:0];
            rsp_data_reg.none_ready       <= (summary_reg == '0);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // summary changes only as the modify step completes
    a_summary_update: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(summary_reg) |-> $past(state_reg) == ST_MODIFY)
        else $error("summary word changed outside the modify step");

    // a result appears only out of the search step
    a_rsp_from_search: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == ST_SEARCH)
        else $error("result raised outside the search step");

    // an empty map reports zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_data_reg.none_ready |-> rsp_data_reg.highest_plus_one == 9'd0)
        else $error("empty map reported a nonzero priority");

endmodule

/* sv/pbm_lead_one.sv */
// leading-one position plus one of a vector, zero when the vector is empty
module pbm_lead_one #(
    parameter int WIDTH = 16
) (
    input  logic [WIDTH-1:0]             vec,
    output logic [$clog2(WIDTH+1)-1:0]   pos_plus_one
);

    localparam int PW = $clog2(WIDTH + 1);

    always_comb
    begin
        pos_plus_one = '0;
        for (int i = 0; i < WIDTH; i++)
        begin
            if (vec[i])
            begin
                pos_plus_one = PW'(i + 1);
            end
        end
    end

endmodule

/* sv/pbm_word_ram.sv */
// bitmap word memory, one write and one registered read a cycle, valid bit per entry
module pbm_word_ram #(
    parameter int WORD_BITS = 16,
    parameter int NUM_WORDS = 16,
    parameter int AW        = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [WORD_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] valid_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // never-written entries read as zero
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* test/tb.sv */
// self-checking testbench for the two-level priority bitmap unit
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_BITS   = 16;
    localparam int NUM_WORDS   = 16;
    localparam int NUM_PRIOS   = WORD_BITS * NUM_WORDS;
    localparam int RANDOM_REQS = 750;
    localparam int IDLE_PCT    = 31;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 12;
    localparam int CYCLE_LIMIT = 200000;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    pbm_pkg::req_word_t req_data;
    logic               rsp_valid;
    logic               rsp_ready;
    pbm_pkg::rsp_word_t rsp_data;

    two_level_priority_bitmap_unit #(
        .WORD_BITS (WORD_BITS),
        .NUM_WORDS (NUM_WORDS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    // words waiting to be offered, and answers waiting to come back
    pbm_pkg::req_word_t pending_reqs[$];
    pbm_pkg::rsp_word_t expected_answers[$];

    // own copy of the ready map, advanced on every accepted request word
    logic [WORD_BITS-1:0] ready_map [NUM_WORDS];
    logic [NUM_WORDS-1:0] word_summary;

    // what the stimulus generator believes is marked, used to aim clears
    logic [NUM_PRIOS-1:0] gen_marked;
    int                   gen_count;

    int  error_count;
    int  req_sent;
    int  rsp_seen;
    int  cycle_count;
    int  hold_left;
    bit  hold_done;

    // clock and timeout
    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // apply one request word to the ready map and return the answer it yields:
    // summary search first, then the search inside the word it selects
    function automatic pbm_pkg::rsp_word_t apply_request(pbm_pkg::req_word_t w);
        int                 widx;
        int                 bpos;
        int                 top;
        pbm_pkg::rsp_word_t r;
        widx = w.priority_req / WORD_BITS;
        bpos = w.priority_req % WORD_BITS;
        // a priority beyond the map leaves everything as it is
        if (widx < NUM_WORDS)
        begin
            if (w.cmd == pbm_pkg::CMD_SET)
            begin
                ready_map[widx][bpos] = 1'b1;
                word_summary[widx]    = 1'b1;
            end
            else
            begin
                ready_map[widx][bpos] = 1'b0;
                if (ready_map[widx] == '0)
                    word_summary[widx] = 1'b0;
            end
        end
        top = 0;
        for (int i = 0; i < NUM_WORDS; i++)
            if (word_summary[i])
                top = i + 1;
        r.highest_plus_one = '0;
        if (top != 0)
        begin
            r.highest_plus_one = 9'((top - 1) * WORD_BITS);
            for (int i = 0; i < WORD_BITS; i++)
                if (ready_map[top - 1][i])
                    r.highest_plus_one = 9'((top - 1) * WORD_BITS + i + 1);
        end
        r.none_ready = (word_summary == '0);
        return r;
    endfunction

    // queue one request word and track what it leaves marked
    task automatic add_req(logic op, int prio);
        pbm_pkg::req_word_t w;
        w.cmd          = op;
        w.priority_req = 8'(prio);
        pending_reqs.push_back(w);
        gen_count++;
        if (prio < NUM_PRIOS)
            gen_marked[prio] = (op == pbm_pkg::CMD_SET);
    endtask

    // clear every marked priority in random order, emptying the map
    task automatic clear_all_marked();
        int picks[$];
        int k;
        for (int p = 0; p < NUM_PRIOS; p++)
            if (gen_marked[p])
                picks.push_back(p);
        while (picks.size() != 0)
        begin
            k = $urandom_range(0, picks.size() - 1);
            add_req(pbm_pkg::CMD_CLR, picks[k]);
            picks.delete(k);
        end
    endtask

    // clear a marked priority of the given word if one exists, else any of its bits
    task automatic clear_in_word(int widx);
        int start;
        int p;
        start = $urandom_range(0, WORD_BITS - 1);
        p     = widx * WORD_BITS + start;
        for (int i = 0; i < WORD_BITS; i++)
            if (gen_marked[widx * WORD_BITS + (start + i) % WORD_BITS])
                p = widx * WORD_BITS + (start + i) % WORD_BITS;
        add_req(pbm_pkg::CMD_CLR, p);
    endtask

    // stimulus, reset and end of run
    initial
    begin
        int focus_word;
        int roll;
        rst_n       = 1'b0;
        error_count = 0;
        gen_marked  = '0;
        gen_count   = 0;
        focus_word  = 0;

        // directed words: extremes, both operations, redundant marks and clears
        add_req(pbm_pkg::CMD_CLR, 0);      // clear on an empty map
        add_req(pbm_pkg::CMD_SET, 0);      // lowest priority
        add_req(pbm_pkg::CMD_SET, 255);    // highest priority
        add_req(pbm_pkg::CMD_SET, 255);    // mark of an already marked priority
        add_req(pbm_pkg::CMD_CLR, 128);    // clear of an unmarked priority in an empty word
        add_req(pbm_pkg::CMD_SET, 130);
        add_req(pbm_pkg::CMD_CLR, 131);    // clear of an unmarked bit in a non-empty word
        add_req(pbm_pkg::CMD_CLR, 255);    // top drops to the middle word
        add_req(pbm_pkg::CMD_SET, 143);    // top bit of a word
        add_req(pbm_pkg::CMD_SET, 144);    // bottom bit of the next word
        add_req(pbm_pkg::CMD_CLR, 144);
        add_req(pbm_pkg::CMD_CLR, 130);
        add_req(pbm_pkg::CMD_CLR, 143);    // word empties, summary bit drops
        add_req(pbm_pkg::CMD_SET, 15);
        add_req(pbm_pkg::CMD_SET, 240);
        add_req(pbm_pkg::CMD_SET, 170);
        add_req(pbm_pkg::CMD_SET, 85);
        add_req(pbm_pkg::CMD_CLR, 240);
        add_req(pbm_pkg::CMD_CLR, 170);
        add_req(pbm_pkg::CMD_CLR, 85);
        add_req(pbm_pkg::CMD_CLR, 15);
        add_req(pbm_pkg::CMD_CLR, 0);      // map empty again
        add_req(pbm_pkg::CMD_CLR, 0);
        // with sixteen words of sixteen bits every 8-bit priority lies in the map

        // random words, mostly clustered on one word so that words fill and drain
        while (gen_count < RANDOM_REQS)
        begin
            if (gen_count % 40 == 0)
                focus_word = $urandom_range(0, NUM_WORDS - 1);
            roll = $urandom_range(0, 99);
            if (roll < 2)
                clear_all_marked();
            else if (roll < 42)
                add_req(pbm_pkg::CMD_SET,
                        focus_word * WORD_BITS + $urandom_range(0, WORD_BITS - 1));
            else if (roll < 57)
                add_req(pbm_pkg::CMD_SET, $urandom_range(0, 255));
            else if (roll < 85)
                clear_in_word(focus_word);
            else if (roll < 92)
                clear_in_word($urandom_range(0, NUM_WORDS - 1));
            else
                add_req(pbm_pkg::CMD_CLR, $urandom_range(0, 255));
        end
        clear_all_marked();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // look mid-cycle so the clocked processes have settled
        while (pending_reqs.size() != 0 || req_valid || expected_answers.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (expected_answers.size() != 0 || pending_reqs.size() != 0)
        begin
            $display("%0t: %0d answers still missing at the end", $time,
                     expected_answers.size());
            error_count++;
        end

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // request driver: next word goes out once the current one is taken;
    // idles at random except in a calm window
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
            req_sent  <= 0;
        end
        else if (!req_valid || req_ready)
        begin
            if (pending_reqs.size() != 0 &&
                ((req_sent >= 200 && req_sent < 350) ||
                 $urandom_range(0, 99) >= IDLE_PCT))
            begin
                req_valid <= 1'b1;
                req_data  <= pending_reqs.pop_front();
                req_sent  <= req_sent + 1;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // response ready: random stalls, a calm window, and one long hold-off
    // that lets the unit back up into its request side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && rsp_seen >= 300)
        begin
            rsp_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (rsp_seen >= 450 && rsp_seen < 600)
        begin
            rsp_ready <= 1'b1;
        end
        else
        begin
            rsp_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // monitor: predict on every accepted request, check every accepted answer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                expected_answers.push_back(apply_request(req_data));
            if (rsp_valid && rsp_ready)
            begin
                rsp_seen <= rsp_seen + 1;
                if (expected_answers.size() == 0)
                begin
                    $display("%0t: unexpected answer highest_plus_one %0d none_ready %0b",
                             $time, rsp_data.highest_plus_one, rsp_data.none_ready);
                    error_count++;
                end
                else
                begin
                    if (rsp_data.highest_plus_one !== expected_answers[0].highest_plus_one)
                    begin
                        $display("%0t: highest_plus_one expected %0d actual %0d", $time,
                                 expected_answers[0].highest_plus_one,
                                 rsp_data.highest_plus_one);
                        error_count++;
                    end
                    if (rsp_data.none_ready !== expected_answers[0].none_ready)
                    begin
                        $display("%0t: none_ready expected %0b actual %0b", $time,
                                 expected_answers[0].none_ready, rsp_data.none_ready);
                        error_count++;
                    end
                    void'(expected_answers.pop_front());
                end
            end
        end
        else
        begin
            rsp_seen <= 0;
            for (int i = 0; i < NUM_WORDS; i++)
                ready_map[i] = '0;
            word_summary = '0;
        end
    end

    initial cycle_count = 0;

endmodule
